>>> src/tsc_pkg.sv
package tsc_pkg;

	// Number format and series length.
	localparam int FRAC_BITS = 30;
	localparam int TERMS     = 12;

	// Field and datapath widths. The term magnitude never exceeds 2^31 and x^2 never
	// exceeds 2^32 in Q2.30, so the series runs on 32/33-bit magnitudes.
	localparam int ANGLE_W     = 32;
	localparam int MAG_W       = 32;
	localparam int X2_W        = 33;
	localparam int OP_W        = 34;
	localparam int PROD_W      = 2 * OP_W;
	localparam int SUM_W       = 36;
	localparam int K_W         = $clog2(TERMS + 1);
	localparam int D_W         = 10;
	localparam int RECIP_SHIFT = OP_W;

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [MAG_W-1:0]  ONE_MAG    = MAG_W'(1) << FRAC_BITS;
	localparam longint unsigned   RECIP_ONE  = 64'd1 << RECIP_SHIFT;

	localparam logic signed [SUM_W-1:0] WORD_MAX = SUM_W'(32'sh7fff_ffff);
	localparam logic signed [SUM_W-1:0] WORD_MIN = -(SUM_W'(64'sh8000_0000));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_X2,
		ST_CHK,
		ST_P,
		ST_RCP,
		ST_QEST,
		ST_CORR,
		ST_OUT
	} tsc_state_t;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_TX,
		MUL_NR,
		MUL_QD
	} tsc_mul_sel_t;

	typedef struct packed {
		logic         load_angle;
		logic         mul_en;
		tsc_mul_sel_t mul_sel;
		logic         load_x2;
		logic         start_sin;
		logic         start_cos;
		logic         add_term;
		logic         load_n;
		logic         load_q;
		logic         load_t;
		logic         store_sin;
		logic         out_load;
	} tsc_cmd_t;

	typedef struct packed {
		logic done;
		logic is_cos;
	} tsc_status_t;

	// Divisor i*(i-1) for term step k: i runs 3,5,7,... for sine and 2,4,6,... for cosine.
	function automatic logic [D_W-1:0] d_of(logic is_cos, logic [K_W-1:0] k);
		logic [D_W-1:0] i;
		i = is_cos ? (D_W'({k, 1'b0}) + D_W'(2)) : (D_W'({k, 1'b0}) + D_W'(3));
		return D_W'(i * (i - D_W'(1)));
	endfunction

	// floor(2^34 / d) for every divisor the series uses.
	function automatic logic [OP_W-1:0] recip_of(logic [D_W-1:0] d);
		case (d)
			D_W'(2):   return OP_W'(RECIP_ONE / 2);
			D_W'(6):   return OP_W'(RECIP_ONE / 6);
			D_W'(12):  return OP_W'(RECIP_ONE / 12);
			D_W'(20):  return OP_W'(RECIP_ONE / 20);
			D_W'(30):  return OP_W'(RECIP_ONE / 30);
			D_W'(42):  return OP_W'(RECIP_ONE / 42);
			D_W'(56):  return OP_W'(RECIP_ONE / 56);
			D_W'(72):  return OP_W'(RECIP_ONE / 72);
			D_W'(90):  return OP_W'(RECIP_ONE / 90);
			D_W'(110): return OP_W'(RECIP_ONE / 110);
			D_W'(132): return OP_W'(RECIP_ONE / 132);
			D_W'(156): return OP_W'(RECIP_ONE / 156);
			D_W'(182): return OP_W'(RECIP_ONE / 182);
			D_W'(210): return OP_W'(RECIP_ONE / 210);
			D_W'(240): return OP_W'(RECIP_ONE / 240);
			D_W'(272): return OP_W'(RECIP_ONE / 272);
			D_W'(306): return OP_W'(RECIP_ONE / 306);
			D_W'(342): return OP_W'(RECIP_ONE / 342);
			D_W'(380): return OP_W'(RECIP_ONE / 380);
			D_W'(420): return OP_W'(RECIP_ONE / 420);
			D_W'(462): return OP_W'(RECIP_ONE / 462);
			D_W'(506): return OP_W'(RECIP_ONE / 506);
			D_W'(552): return OP_W'(RECIP_ONE / 552);
			D_W'(600): return OP_W'(RECIP_ONE / 600);
			default:   return '0;
		endcase
	endfunction

	// Clamp a running sum to the signed 32-bit result range.
	function automatic logic signed [ANGLE_W-1:0] sat_word(logic signed [SUM_W-1:0] v);
		if (v > WORD_MAX) begin
			return ANGLE_W'(WORD_MAX);
		end else if (v < WORD_MIN) begin
			return ANGLE_W'(WORD_MIN);
		end
		return ANGLE_W'(v);
	endfunction

endpackage

>>> src/tsc_if.sv
interface tsc_angle_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tsc_pkg::ANGLE_W-1:0]   angle;

	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

interface tsc_trig_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tsc_pkg::ANGLE_W-1:0]   sine;
	logic signed [tsc_pkg::ANGLE_W-1:0]   cosine;

	modport source (output valid, output sine, output cosine, input ready);
	modport sink   (input valid, input sine, input cosine, output ready);
endinterface

>>> src/tsc_dp.sv
module tsc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsc_pkg::tsc_cmd_t                   cmd,
	input  logic signed [tsc_pkg::ANGLE_W-1:0]  angle,
	output tsc_pkg::tsc_status_t                status,
	output logic signed [tsc_pkg::ANGLE_W-1:0]  sine,
	output logic signed [tsc_pkg::ANGLE_W-1:0]  cosine
);

	logic                                neg_q;
	logic [tsc_pkg::MAG_W-1:0]           mag_q;
	logic [tsc_pkg::X2_W-1:0]            x2_q;
	logic [tsc_pkg::MAG_W-1:0]           t_q;
	logic [tsc_pkg::OP_W-1:0]            n_q;
	logic [tsc_pkg::OP_W-1:0]            q_q;
	logic [tsc_pkg::PROD_W-1:0]          prod_q;
	logic signed [tsc_pkg::SUM_W-1:0]    sum_q;
	logic                                tneg_q;
	logic                                is_cos_q;
	logic [tsc_pkg::K_W-1:0]             k_q;
	logic signed [tsc_pkg::ANGLE_W-1:0]  sin_hold_q;
	logic signed [tsc_pkg::ANGLE_W-1:0]  sine_q;
	logic signed [tsc_pkg::ANGLE_W-1:0]  cosine_q;

	logic [tsc_pkg::OP_W-1:0]            mul_a;
	logic [tsc_pkg::OP_W-1:0]            mul_b;
	logic [tsc_pkg::D_W-1:0]             d;
	logic [tsc_pkg::PROD_W-1:0]          rounded;
	logic [tsc_pkg::OP_W-1:0]            n_next;
	logic [tsc_pkg::OP_W-1:0]            rem;
	logic [tsc_pkg::MAG_W-1:0]           t_next;
	logic signed [tsc_pkg::SUM_W-1:0]    t_ext;
	logic signed [tsc_pkg::SUM_W-1:0]    sin_signed;
	logic [tsc_pkg::MAG_W-1:0]           mag_in;

	assign d       = tsc_pkg::d_of(is_cos_q, k_q);
	assign rounded = prod_q + tsc_pkg::ROUND_HALF;
	assign n_next  = rounded[tsc_pkg::FRAC_BITS +: tsc_pkg::OP_W]
		+ tsc_pkg::OP_W'(d >> 1);
	// The estimate from the reciprocal is low by at most one, so one compare fixes it.
	assign rem     = n_q - prod_q[tsc_pkg::OP_W-1:0];
	assign t_next  = (rem >= tsc_pkg::OP_W'(d)) ? tsc_pkg::MAG_W'(q_q + tsc_pkg::OP_W'(1))
		: tsc_pkg::MAG_W'(q_q);
	assign t_ext   = $signed({{(tsc_pkg::SUM_W - tsc_pkg::MAG_W){1'b0}}, t_q});
	assign sin_signed = neg_q ? -sum_q : sum_q;
	assign mag_in  = angle[tsc_pkg::ANGLE_W-1] ? (~angle + tsc_pkg::MAG_W'(1)) : angle;

	always_comb begin
		case (cmd.mul_sel)
			tsc_pkg::MUL_SQ: begin
				mul_a = tsc_pkg::OP_W'(mag_q);
				mul_b = tsc_pkg::OP_W'(mag_q);
			end
			tsc_pkg::MUL_TX: begin
				mul_a = tsc_pkg::OP_W'(t_q);
				mul_b = tsc_pkg::OP_W'(x2_q);
			end
			tsc_pkg::MUL_NR: begin
				mul_a = n_q;
				mul_b = tsc_pkg::recip_of(d);
			end
			tsc_pkg::MUL_QD: begin
				mul_a = prod_q[tsc_pkg::PROD_W-1:tsc_pkg::RECIP_SHIFT];
				mul_b = tsc_pkg::OP_W'(d);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			is_cos_q <= 1'b0;
			tneg_q   <= 1'b0;
		end else begin
			if (cmd.start_sin || cmd.start_cos) begin
				k_q      <= '0;
				is_cos_q <= cmd.start_cos;
				tneg_q   <= 1'b0;
			end else if (cmd.load_t) begin
				k_q    <= k_q + tsc_pkg::K_W'(1);
				tneg_q <= ~tneg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_angle) begin
			neg_q <= angle[tsc_pkg::ANGLE_W-1];
			mag_q <= mag_in;
		end
		if (cmd.mul_en) begin
			prod_q <= tsc_pkg::PROD_W'(mul_a) * tsc_pkg::PROD_W'(mul_b);
		end
		if (cmd.load_x2) begin
			x2_q <= rounded[tsc_pkg::FRAC_BITS +: tsc_pkg::X2_W];
		end
		if (cmd.load_n) begin
			n_q <= n_next;
		end
		if (cmd.load_q) begin
			q_q <= prod_q[tsc_pkg::PROD_W-1:tsc_pkg::RECIP_SHIFT];
		end
		if (cmd.start_sin) begin
			t_q   <= mag_q;
			sum_q <= '0;
		end else if (cmd.start_cos) begin
			t_q   <= tsc_pkg::ONE_MAG;
			sum_q <= '0;
		end else begin
			if (cmd.load_t) begin
				t_q <= t_next;
			end
			if (cmd.add_term) begin
				sum_q <= tneg_q ? (sum_q - t_ext) : (sum_q + t_ext);
			end
		end
		if (cmd.store_sin) begin
			sin_hold_q <= tsc_pkg::sat_word(sin_signed);
		end
		if (cmd.out_load) begin
			sine_q   <= sin_hold_q;
			cosine_q <= tsc_pkg::sat_word(sum_q);
		end
	end

	assign status.done   = (t_q == '0) || (k_q == tsc_pkg::K_W'(tsc_pkg::TERMS));
	assign status.is_cos = is_cos_q;
	assign sine          = sine_q;
	assign cosine        = cosine_q;

`ifndef SYNTHESIS
	// The term counter never runs past the series length.
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= tsc_pkg::K_W'(tsc_pkg::TERMS))
		else $error("term counter ran past the series length");

	// After the reciprocal estimate the remainder must lie below twice the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_t |-> (rem < (tsc_pkg::OP_W'(d) << 1)))
		else $error("quotient estimate is off by more than one");
`endif

endmodule

>>> src/tsc_ctrl.sv
module tsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsc_pkg::tsc_status_t  status,
	input  logic                  arg_valid,
	input  logic                  res_ready,
	output logic                  arg_ready,
	output logic                  res_valid,
	output tsc_pkg::tsc_cmd_t     cmd
);

	tsc_pkg::tsc_state_t state_q;
	tsc_pkg::tsc_state_t state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		arg_ready = 1'b0;
		case (state_q)
			tsc_pkg::ST_IDLE: begin
				arg_ready = 1'b1;
				if (arg_valid) begin
					cmd.load_angle = 1'b1;
					state_d        = tsc_pkg::ST_SQ;
				end
			end
			tsc_pkg::ST_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tsc_pkg::MUL_SQ;
				state_d     = tsc_pkg::ST_X2;
			end
			tsc_pkg::ST_X2: begin
				cmd.load_x2   = 1'b1;
				cmd.start_sin = 1'b1;
				state_d       = tsc_pkg::ST_CHK;
			end
			tsc_pkg::ST_CHK: begin
				if (status.done) begin
					if (status.is_cos) begin
						state_d = tsc_pkg::ST_OUT;
					end else begin
						cmd.store_sin = 1'b1;
						cmd.start_cos = 1'b1;
					end
				end else begin
					cmd.add_term = 1'b1;
					cmd.mul_en   = 1'b1;
					cmd.mul_sel  = tsc_pkg::MUL_TX;
					state_d      = tsc_pkg::ST_P;
				end
			end
			tsc_pkg::ST_P: begin
				cmd.load_n = 1'b1;
				state_d    = tsc_pkg::ST_RCP;
			end
			tsc_pkg::ST_RCP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tsc_pkg::MUL_NR;
				state_d     = tsc_pkg::ST_QEST;
			end
			tsc_pkg::ST_QEST: begin
				cmd.load_q  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tsc_pkg::MUL_QD;
				state_d     = tsc_pkg::ST_CORR;
			end
			tsc_pkg::ST_CORR: begin
				cmd.load_t = 1'b1;
				state_d    = tsc_pkg::ST_CHK;
			end
			tsc_pkg::ST_OUT: begin
				if (!out_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = tsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsc_pkg::ST_IDLE;
			end
		endcase
	end

	assign res_valid = out_valid_q;

`ifndef SYNTHESIS
	// An accepted angle always starts with the squaring step.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(arg_valid && arg_ready) |=> (state_q == tsc_pkg::ST_SQ))
		else $error("accepted word did not start the squaring step");

	// The output register is only overwritten once the previous word is gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result overwritten before it was taken");
`endif

endmodule

>>> src/taylor_sin_cos_unit_core.sv
// From accepting an angle to a valid result, the controller squares it, sums the Ns sine
// and Nc cosine terms (each at most 12) and loads the output register; each term passes
// the check, product, reciprocal, estimate and correction states on the one multiplier.
// A new angle is taken once the last result sits in the output register, even unread.
// Reset (arst_n, asynchronous, active low) empties the output register and returns the
// controller to idle; in the datapath only the term counter, series and sign flags reset.
module taylor_sin_cos_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	tsc_angle_if.sink  arg,
	tsc_trig_if.source res
);

	// The controller sequences the series one term at a time. Each term goes
	// through multiply by x^2 with rounding, a multiply by the reciprocal of
	// i*(i-1) from a constant table, and a multiply-back that corrects the
	// quotient estimate by at most one. The sine series runs first, then the
	// cosine series, on the same datapath.
	tsc_pkg::tsc_cmd_t    cmd;
	tsc_pkg::tsc_status_t status;

	tsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.arg_valid (arg.valid),
		.res_ready (res.ready),
		.arg_ready (arg.ready),
		.res_valid (res.valid),
		.cmd       (cmd)
	);

	// The datapath owns every arithmetic register and the output payload.
	tsc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.angle  (arg.angle),
		.status (status),
		.sine   (res.sine),
		.cosine (res.cosine)
	);

endmodule
